>>> hw/rtl/risc_instruction_execute_top_macros.svh
// ---------------------------------------------------------------------------
// risc instruction execute: assertion macros
// concurrent checks that vanish in synthesis builds
// ---------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define RIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define RIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RIE_ASSERT(lbl, prop, msg)
`define RIE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/rie_pkg.sv
// ---------------------------------------------------------------------------
// rie_pkg
// shared types, opcodes and constants of the instruction execute block
// ---------------------------------------------------------------------------
package rie_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned NUM_REGS      = 16;
  localparam int unsigned REG_AW        = 4;
  localparam int unsigned IMM_W         = 20;
  localparam int unsigned PC_OUT_W      = 10;
  localparam int unsigned DMEM_DEPTH_DEF = 4096;
  localparam int unsigned PC_BITS_DEF   = 10;

  localparam logic [REG_AW-1:0] ZERO_IDX = 4'd0;
  localparam logic [REG_AW-1:0] IMM_IDX  = 4'd1;
  localparam logic [REG_AW-1:0] RA_IDX   = 4'd15;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_AND  = 8'd2,
    OP_OR   = 8'd3,
    OP_XOR  = 8'd4,
    OP_MUL  = 8'd5,
    OP_SLL  = 8'd6,
    OP_SRA  = 8'd7,
    OP_SRL  = 8'd8,
    OP_BEQ  = 8'd9,
    OP_BNE  = 8'd10,
    OP_BLT  = 8'd11,
    OP_BGT  = 8'd12,
    OP_BLE  = 8'd13,
    OP_BGE  = 8'd14,
    OP_JAL  = 8'd15,
    OP_LW   = 8'd16,
    OP_SW   = 8'd17,
    OP_RETI = 8'd18,
    OP_IN   = 8'd19,
    OP_OUT  = 8'd20,
    OP_HALT = 8'd21
  } op_e;

  // decoded item held in the operand stage
  typedef struct packed {
    logic [7:0]          mode;
    logic [REG_AW-1:0]   rd;
    logic [REG_AW-1:0]   rs;
    logic [REG_AW-1:0]   rt;
    logic [XLEN-1:0]     imm;
    logic [XLEN-1:0]     io_rdata;
    logic [PC_OUT_W-1:0] irq;
  } s1_t;

  typedef struct packed {
    logic [PC_OUT_W-1:0] next_pc;
    logic [1:0]          cycles_taken;
    logic                io_read;
    logic                io_write;
    logic [XLEN-1:0]     io_address;
    logic [XLEN-1:0]     io_write_data;
    logic                clear_interrupt;
    logic                halted;
    logic                error;
  } res_t;

  // result stage: item result plus pending register write
  typedef struct packed {
    res_t              res;
    logic              wen;
    logic              is_lw;
    logic [REG_AW-1:0] waddr;
    logic [XLEN-1:0]   wdata;
  } s2_t;

  function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_W-1:0] w);
    return {{(XLEN-IMM_W){w[IMM_W-1]}}, w};
  endfunction

endpackage

>>> hw/rtl/rie_in_if.sv
// ---------------------------------------------------------------------------
// rie_in_if
// instruction item channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface rie_in_if import rie_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [7:0]            mode;
  logic [REG_AW-1:0]     dest_reg;
  logic [REG_AW-1:0]     src_a_reg;
  logic [REG_AW-1:0]     src_b_reg;
  logic [IMM_W-1:0]      imm_word;
  logic signed [XLEN-1:0] io_read_data;
  logic [PC_OUT_W-1:0]   irq_return;

  modport source (
    output valid, mode, dest_reg, src_a_reg, src_b_reg, imm_word, io_read_data,
           irq_return,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_reg, src_a_reg, src_b_reg, imm_word, io_read_data,
           irq_return,
    output ready
  );
endinterface

>>> hw/rtl/rie_out_if.sv
// ---------------------------------------------------------------------------
// rie_out_if
// execution result channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface rie_out_if import rie_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PC_OUT_W-1:0]    next_pc;
  logic [1:0]             cycles_taken;
  logic                   io_read;
  logic                   io_write;
  logic signed [XLEN-1:0] io_address;
  logic signed [XLEN-1:0] io_write_data;
  logic                   clear_interrupt;
  logic                   halted;
  logic                   error;

  modport source (
    output valid, next_pc, cycles_taken, io_read, io_write, io_address,
           io_write_data, clear_interrupt, halted, error,
    input  ready
  );
  modport sink (
    input  valid, next_pc, cycles_taken, io_read, io_write, io_address,
           io_write_data, clear_interrupt, halted, error,
    output ready
  );
endinterface

>>> hw/rtl/rie_regfile.sv
// ---------------------------------------------------------------------------
// rie_regfile
// register file: two synchronous copies, three read ports, one write port
// ---------------------------------------------------------------------------
module rie_regfile import rie_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [REG_AW-1:0] rs_addr_i,
  input  logic [REG_AW-1:0] rt_addr_i,
  input  logic [REG_AW-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [REG_AW-1:0] wr_addr_i,
  input  logic [XLEN-1:0]   wr_data_i,
  output logic [XLEN-1:0]   rs_data_o,
  output logic [XLEN-1:0]   rt_data_o,
  output logic [XLEN-1:0]   rd_data_o
);

  // copy ab serves rs/rt, copy d serves rd
  logic [XLEN-1:0]     mem_ab_q [NUM_REGS];
  logic [XLEN-1:0]     mem_d_q  [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;
  logic [XLEN-1:0]     rs_raw_q, rt_raw_q, rd_raw_q;
  logic                rs_ok_q, rt_ok_q, rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_ab_q[wr_addr_i] <= wr_data_i;
      mem_d_q[wr_addr_i]  <= wr_data_i;
    end
    if (rd_en_i) begin
      rs_raw_q <= mem_ab_q[rs_addr_i];
      rt_raw_q <= mem_ab_q[rt_addr_i];
      rd_raw_q <= mem_d_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rs_ok_q <= 1'b0;
      rt_ok_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rs_ok_q <= valid_q[rs_addr_i];
        rt_ok_q <= valid_q[rt_addr_i];
        rd_ok_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rs_data_o = rs_ok_q ? rs_raw_q : '0;
  assign rt_data_o = rt_ok_q ? rt_raw_q : '0;
  assign rd_data_o = rd_ok_q ? rd_raw_q : '0;

endmodule

>>> hw/rtl/rie_dmem.sv
// ---------------------------------------------------------------------------
// rie_dmem
// data memory: one write and one read port, clearing sweep after reset
// ---------------------------------------------------------------------------
module rie_dmem import rie_pkg::*; #(
  parameter int unsigned DMEM_DEPTH = DMEM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DMEM_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [XLEN-1:0] wr_data_i,
  output logic [XLEN-1:0] rd_data_o,
  output logic          busy_o
);

  logic [XLEN-1:0] mem_q [DMEM_DEPTH];
  logic [AW-1:0]   clr_addr_q;
  logic            busy_q;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [XLEN-1:0] wdata;

  assign we    = busy_q | wr_en_i;
  assign waddr = busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DMEM_DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;

endmodule

>>> hw/rtl/risc_instruction_execute_top.sv
// ---------------------------------------------------------------------------
// risc_instruction_execute_top
// executes one decoded instruction per item against register file and memory
//
//   channel  dir  modport  contents
//   in_i     in   sink     opcode, register indexes, immediate, io value, irq
//   out_o    out  source   next pc, cycles, io request, reti/halt/error flags
//
// one item per cycle unless the result side stalls or the clear runs
// stage one reads the register file, stage two executes, forwards and
// issues the data memory access, the result register then writes back
// after reset a sweep clears every data memory word, no item is taken
// meanwhile; depth must be a power of two, which the block does not check
// a stalled result holds the pipe, one more item may enter behind it
// ---------------------------------------------------------------------------
`include "risc_instruction_execute_top_macros.svh"

module risc_instruction_execute_top import rie_pkg::*; #(
  parameter int unsigned DMEM_DEPTH = DMEM_DEPTH_DEF,
  parameter int unsigned PC_BITS    = PC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  rie_in_if.sink    in_i,
  rie_out_if.source out_o
);

  localparam int unsigned DMEM_AW = $clog2(DMEM_DEPTH);

  s1_t               s1_q;
  logic              s1_valid_q;
  s2_t               s2_q, s2_d;
  logic              s2_valid_q;
  logic [PC_BITS-1:0] pc_q, pc_d;

  logic              wb_en_q;
  logic [REG_AW-1:0] wb_addr_q;
  logic [XLEN-1:0]   wb_data_q;

  logic              adv, in_acc, clr_busy;
  logic [XLEN-1:0]   rs_raw, rt_raw, rd_raw, dmem_rdata;
  logic              rf_we;
  logic [XLEN-1:0]   rf_wdata;
  logic              p2_hit_en;
  logic [XLEN-1:0]   p2_fwd_data;

  logic              dm_re, dm_we;
  logic [DMEM_AW-1:0] dm_addr;

  assign adv       = !s2_valid_q || out_o.ready;
  assign in_i.ready = (!s1_valid_q || adv) && !clr_busy;
  assign in_acc    = in_i.valid && in_i.ready;

  assign p2_hit_en   = s2_valid_q && s2_q.wen;
  assign p2_fwd_data = s2_q.is_lw ? dmem_rdata : s2_q.wdata;
  assign rf_we       = adv && p2_hit_en;
  assign rf_wdata    = p2_fwd_data;

  rie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rs_addr_i (in_i.src_a_reg),
    .rt_addr_i (in_i.src_b_reg),
    .rd_addr_i (in_i.dest_reg),
    .wr_en_i   (rf_we),
    .wr_addr_i (s2_q.waddr),
    .wr_data_i (rf_wdata),
    .rs_data_o (rs_raw),
    .rt_data_o (rt_raw),
    .rd_data_o (rd_raw)
  );

  // newest pending write wins, then the write made as the operands were read
  function automatic logic [XLEN-1:0] fwd(
    input logic [REG_AW-1:0] addr,
    input logic [XLEN-1:0]   raw,
    input logic              hit2_en,
    input logic [REG_AW-1:0] hit2_addr,
    input logic [XLEN-1:0]   hit2_data,
    input logic              wb_en,
    input logic [REG_AW-1:0] wb_addr,
    input logic [XLEN-1:0]   wb_data
  );
    logic [XLEN-1:0] v;
    v = raw;
    if (hit2_en && hit2_addr == addr) begin
      v = hit2_data;
    end else if (wb_en && wb_addr == addr) begin
      v = wb_data;
    end
    return v;
  endfunction

  logic              assigning, is_branch, err, need, cond;
  logic [PC_BITS-1:0] pc1;
  logic [PC_BITS:0]  ret_addr;
  logic [XLEN-1:0]   a, b, d, sum, res;

  always_comb begin
    assigning = (s1_q.mode <= OP_SRL) || s1_q.mode == OP_LW || s1_q.mode == OP_IN;
    is_branch = (s1_q.mode >= OP_BEQ) && (s1_q.mode <= OP_BGE);
    err       = (s1_q.mode > OP_HALT) || (assigning && s1_q.rd == IMM_IDX);
    need      = 1'b0;
    if (s1_q.mode <= OP_SW || s1_q.mode == OP_IN || s1_q.mode == OP_OUT) begin
      if (s1_q.mode == OP_JAL) begin
        need = (s1_q.rd == IMM_IDX);
      end else if (assigning) begin
        need = (s1_q.rs == IMM_IDX) || (s1_q.rt == IMM_IDX);
      end else begin
        need = (s1_q.rd == IMM_IDX) || (s1_q.rs == IMM_IDX) || (s1_q.rt == IMM_IDX);
      end
    end
    pc1      = need ? pc_q + 1'b1 : pc_q;
    ret_addr = {1'b0, pc1} + {{PC_BITS{1'b0}}, 1'b1};

    a = (s1_q.rs == IMM_IDX) ? s1_q.imm
        : fwd(s1_q.rs, rs_raw, p2_hit_en, s2_q.waddr, p2_fwd_data,
              wb_en_q, wb_addr_q, wb_data_q);
    b = (s1_q.rt == IMM_IDX) ? s1_q.imm
        : fwd(s1_q.rt, rt_raw, p2_hit_en, s2_q.waddr, p2_fwd_data,
              wb_en_q, wb_addr_q, wb_data_q);
    // jal links to r15 before reading rd
    if (s1_q.mode == OP_JAL && s1_q.rd == RA_IDX) begin
      d = XLEN'(ret_addr);
    end else if (s1_q.rd == IMM_IDX) begin
      d = s1_q.imm;
    end else begin
      d = fwd(s1_q.rd, rd_raw, p2_hit_en, s2_q.waddr, p2_fwd_data,
              wb_en_q, wb_addr_q, wb_data_q);
    end
    sum = a + b;

    res  = '0;
    cond = 1'b0;
    unique case (s1_q.mode)
      OP_ADD:  res = a + b;
      OP_SUB:  res = a - b;
      OP_AND:  res = a & b;
      OP_OR:   res = a | b;
      OP_XOR:  res = a ^ b;
      OP_MUL:  res = a * b;
      OP_SLL:  res = a << b[4:0];
      OP_SRA:  res = $unsigned($signed(a) >>> b[4:0]);
      OP_SRL:  res = a >> b[4:0];
      OP_BEQ:  cond = (a == b);
      OP_BNE:  cond = (a != b);
      OP_BLT:  cond = ($signed(a) < $signed(b));
      OP_BGT:  cond = ($signed(b) < $signed(a));
      OP_BLE:  cond = !($signed(b) < $signed(a));
      OP_BGE:  cond = !($signed(a) < $signed(b));
      OP_IN:   res = s1_q.io_rdata;
      default: res = '0;
    endcase

    s2_d       = '0;
    s2_d.waddr = s1_q.rd;
    s2_d.wdata = res;
    pc_d       = pc_q;
    if (err) begin
      s2_d.res.error = 1'b1;
    end else begin
      if (assigning) begin
        s2_d.wen   = (s1_q.rd != ZERO_IDX);
        s2_d.is_lw = (s1_q.mode == OP_LW);
        pc_d       = pc1 + 1'b1;
      end else if (is_branch) begin
        pc_d = cond ? PC_BITS'(d) : pc1 + 1'b1;
      end else if (s1_q.mode == OP_JAL) begin
        s2_d.wen   = 1'b1;
        s2_d.waddr = RA_IDX;
        s2_d.wdata = XLEN'(ret_addr);
        pc_d       = PC_BITS'(d);
      end else if (s1_q.mode == OP_SW) begin
        pc_d = pc1 + 1'b1;
      end else if (s1_q.mode == OP_RETI) begin
        pc_d = PC_BITS'(s1_q.irq);
        s2_d.res.clear_interrupt = 1'b1;
      end else if (s1_q.mode == OP_OUT) begin
        s2_d.res.io_write      = 1'b1;
        s2_d.res.io_address    = sum;
        s2_d.res.io_write_data = d;
        pc_d = pc1 + 1'b1;
      end else begin
        s2_d.res.halted = 1'b1;
      end
      if (s1_q.mode == OP_IN) begin
        s2_d.res.io_read    = 1'b1;
        s2_d.res.io_address = sum;
      end
    end
    s2_d.res.next_pc      = PC_OUT_W'(pc_d);
    s2_d.res.cycles_taken = (need && !err) ? 2'd2 : 2'd1;
  end

  // memory accesses are issued as the item leaves the execute stage
  assign dm_addr = sum[DMEM_AW-1:0];
  assign dm_re   = adv && s1_valid_q && !err && s1_q.mode == OP_LW;
  assign dm_we   = adv && s1_valid_q && !err && s1_q.mode == OP_SW;

  rie_dmem #(.DMEM_DEPTH(DMEM_DEPTH)) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (dm_re),
    .rd_addr_i (dm_addr),
    .wr_en_i   (dm_we),
    .wr_addr_i (dm_addr),
    .wr_data_i (d),
    .rd_data_o (dmem_rdata),
    .busy_o    (clr_busy)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.mode     <= in_i.mode;
      s1_q.rd       <= in_i.dest_reg;
      s1_q.rs       <= in_i.src_a_reg;
      s1_q.rt       <= in_i.src_b_reg;
      s1_q.imm      <= sext_imm(in_i.imm_word);
      s1_q.io_rdata <= in_i.io_read_data;
      s1_q.irq      <= in_i.irq_return;
    end
    if (adv) begin
      s2_q <= s2_d;
    end
    if (rf_we) begin
      wb_addr_q <= s2_q.waddr;
      wb_data_q <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pc_q       <= '0;
      wb_en_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        s2_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          pc_q <= pc_d;
        end
      end
      if (rf_we) begin
        wb_en_q <= 1'b1;
      end
    end
  end

  assign out_o.valid           = s2_valid_q;
  assign out_o.next_pc         = s2_q.res.next_pc;
  assign out_o.cycles_taken    = s2_q.res.cycles_taken;
  assign out_o.io_read         = s2_q.res.io_read;
  assign out_o.io_write        = s2_q.res.io_write;
  assign out_o.io_address      = s2_q.res.io_address;
  assign out_o.io_write_data   = s2_q.res.io_write_data;
  assign out_o.clear_interrupt = s2_q.res.clear_interrupt;
  assign out_o.halted          = s2_q.res.halted;
  assign out_o.error           = s2_q.res.error;

  `RIE_ASSERT(a_no_item_while_clearing, in_acc |-> !clr_busy, "item taken during clear")
  `RIE_ASSERT(a_no_write_r0_r1,
    rf_we |-> (s2_q.waddr != ZERO_IDX && s2_q.waddr != IMM_IDX), "write to r0 or r1")
  `RIE_ASSERT(a_pc_only_on_exec, !(adv && s1_valid_q) |=> $stable(pc_q), "pc moved idle")
  `RIE_ASSERT(a_error_no_side_effects,
    (s2_valid_q && s2_q.res.error) |-> !s2_q.wen, "error item writes register")
  `RIE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!s1_valid_q && !s2_valid_q),
    "pipe not empty in reset")

endmodule

>>> test/tb_scoreboard.sv
// ---------------------------------------------------------------------------
// tb_scoreboard
// instruction execute predictor with its own register file, memory and pc
// ---------------------------------------------------------------------------
package tb_scoreboard_pkg;
  import rie_pkg::*;

  localparam int unsigned TB_DMEM_DEPTH = 4096;
  localparam int unsigned TB_PC_BITS    = 10;

  typedef struct packed {
    logic [7:0]         mode;
    logic [3:0]         rd;
    logic [3:0]         rs;
    logic [3:0]         rt;
    logic [IMM_W-1:0]   imm;
    logic [XLEN-1:0]    io_rdata;
    logic [9:0]         irq;
  } instr_t;

  class exec_scoreboard;
    logic [XLEN-1:0]       regs [NUM_REGS];
    logic [XLEN-1:0]       dmem [TB_DMEM_DEPTH];
    logic [TB_PC_BITS-1:0] pc;
    res_t                  pending [$];
    int                    mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      mismatches = 0;
    endfunction

    function bit slt(logic [XLEN-1:0] a, logic [XLEN-1:0] b);
      return $signed(a) < $signed(b);
    endfunction

    // works out the result of one accepted instruction and updates state
    function void note_instr(instr_t t);
      res_t r;
      op_e op;
      logic [XLEN-1:0] a, b, d, sum, res;
      logic [TB_PC_BITS-1:0] npc;
      bit assigning, need, cond;
      r = '0;
      res = '0;
      cond = 0;
      npc = pc;
      op = op_e'(t.mode);
      assigning = (t.mode <= OP_SRL) || t.mode == OP_LW || t.mode == OP_IN;
      if (t.mode > OP_HALT || (assigning && t.rd == IMM_IDX)) begin
        r.next_pc = pc;
        r.cycles_taken = 2'd1;
        r.error = 1'b1;
        pending.push_back(r);
        return;
      end
      r.cycles_taken = 2'd1;
      if (t.mode <= OP_SW || t.mode == OP_IN || t.mode == OP_OUT) begin
        if (t.mode == OP_JAL) need = (t.rd == IMM_IDX);
        else if (assigning) need = (t.rs == IMM_IDX || t.rt == IMM_IDX);
        else need = (t.rd == IMM_IDX || t.rs == IMM_IDX || t.rt == IMM_IDX);
        if (need) begin
          regs[IMM_IDX] = {{(XLEN-IMM_W){t.imm[IMM_W-1]}}, t.imm};
          npc = npc + 1'b1;
          r.cycles_taken = 2'd2;
        end
      end
      a = regs[t.rs];
      b = regs[t.rt];
      d = regs[t.rd];
      sum = a + b;
      case (op)
        OP_ADD: res = a + b;
        OP_SUB: res = a - b;
        OP_AND: res = a & b;
        OP_OR:  res = a | b;
        OP_XOR: res = a ^ b;
        OP_MUL: res = a * b;
        OP_SLL: res = a << b[4:0];
        OP_SRA: res = $signed(a) >>> b[4:0];
        OP_SRL: res = a >> b[4:0];
        OP_BEQ: cond = (a == b);
        OP_BNE: cond = (a != b);
        OP_BLT: cond = slt(a, b);
        OP_BGT: cond = slt(b, a);
        OP_BLE: cond = !slt(b, a);
        OP_BGE: cond = !slt(a, b);
        OP_LW:  res = dmem[sum % TB_DMEM_DEPTH];
        OP_IN: begin
          res = t.io_rdata;
          r.io_read = 1'b1;
          r.io_address = sum;
        end
        default: ;
      endcase
      if (assigning) begin
        if (t.rd != ZERO_IDX) regs[t.rd] = res;
        npc = npc + 1'b1;
      end else if (t.mode >= OP_BEQ && t.mode <= OP_BGE) begin
        npc = cond ? d[TB_PC_BITS-1:0] : npc + 1'b1;
      end else if (op == OP_JAL) begin
        regs[RA_IDX] = 32'(npc) + 1;
        npc = regs[t.rd][TB_PC_BITS-1:0];
      end else if (op == OP_SW) begin
        dmem[sum % TB_DMEM_DEPTH] = d;
        npc = npc + 1'b1;
      end else if (op == OP_RETI) begin
        npc = t.irq;
        r.clear_interrupt = 1'b1;
      end else if (op == OP_OUT) begin
        r.io_write = 1'b1;
        r.io_address = sum;
        r.io_write_data = d;
        npc = npc + 1'b1;
      end else begin
        r.halted = 1'b1;
      end
      regs[ZERO_IDX] = '0;
      pc = npc;
      r.next_pc = npc;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch\n  expected %p\n  actual   %p", exp, got);
      end
    endfunction
  endclass
endpackage

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// random and directed instruction items against a scoreboarded predictor
// ---------------------------------------------------------------------------
module tb_top;
  import rie_pkg::*;
  import tb_scoreboard_pkg::*;

  localparam int N_RANDOM = 1630;

  logic clk_i;
  logic rst_ni;
  rie_in_if  in_if ();
  rie_out_if out_if ();
  exec_scoreboard sb;
  bit   stim_done;
  bit   long_hold;
  int   rx_count;

  risc_instruction_execute_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** risc_instruction_execute_top: FAILED **");
    $finish;
  end

  // send one instruction item after a random gap
  task automatic send_instr(instr_t t);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if ($urandom_range(0, 1)) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= t.mode;
    in_if.dest_reg     <= t.rd;
    in_if.src_a_reg    <= t.rs;
    in_if.src_b_reg    <= t.rt;
    in_if.imm_word     <= t.imm;
    in_if.io_read_data <= t.io_rdata;
    in_if.irq_return   <= t.irq;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_instr(t);
  endtask

  function automatic logic [3:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return IMM_IDX;
      1: return ZERO_IDX;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t t;
    t.mode = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, OP_HALT));
    // keep errors from dominating
    t.rd = pick_reg();
    if ($urandom_range(0, 3) != 0 && t.rd == IMM_IDX) t.rd = 4'($urandom_range(2, 15));
    t.rs = pick_reg();
    t.rt = pick_reg();
    case ($urandom_range(0, 3))
      0: t.imm = 20'($urandom_range(0, 31));
      1: t.imm = 20'hFFFFF - 20'($urandom_range(0, 31));
      default: t.imm = 20'($urandom);
    endcase
    t.io_rdata = $urandom;
    t.irq = 10'($urandom);
    return t;
  endfunction

  // directed extremes, every opcode, immediates and register zero
  initial begin
    instr_t t;
    int i;
    sb = new();
    stim_done = 0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.dest_reg = '0;
    in_if.src_a_reg = '0;
    in_if.src_b_reg = '0;
    in_if.imm_word = '0;
    in_if.io_read_data = '0;
    in_if.irq_return = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    t = '0;
    t.mode = OP_ADD; t.rd = 4'd2; t.rs = IMM_IDX; t.rt = ZERO_IDX; t.imm = 20'h7FFFF;
    send_instr(t);
    t.rd = 4'd3; t.imm = 20'h80000; send_instr(t);
    t.rd = 4'd4; t.imm = 20'hFFFFF; send_instr(t);
    t.rd = ZERO_IDX; send_instr(t);
    t.mode = OP_SUB; t.rd = IMM_IDX; send_instr(t);
    for (i = OP_SUB; i <= OP_HALT; i++) begin
      t.mode = 8'(i);
      t.rd = (i == OP_JAL) ? IMM_IDX : 4'd5;
      t.rs = 4'd3; t.rt = IMM_IDX;
      t.imm = 20'(i * 3);
      t.io_rdata = 32'h8000_0000;
      t.irq = 10'h3FF;
      send_instr(t);
    end
    t.mode = 8'd22; send_instr(t);
    t.mode = 8'hFF; send_instr(t);
    for (i = 0; i < N_RANDOM; i++) send_instr(rand_instr());
    in_if.valid <= 1'b0;
    stim_done = 1;
  end

  // one long hold-off of the result side to fill the pipe
  initial begin
    long_hold = 0;
    wait (rx_count >= 200);
    long_hold = 1;
    repeat (300) @(posedge clk_i);
    long_hold = 0;
  end

  // result side
  initial begin
    int gap;
    res_t r;
    out_if.ready = 1'b0;
    rx_count = 0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
      if (gap != 0 || long_hold) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (long_hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      r.next_pc         = out_if.next_pc;
      r.cycles_taken    = out_if.cycles_taken;
      r.io_read         = out_if.io_read;
      r.io_write        = out_if.io_write;
      r.io_address      = out_if.io_address;
      r.io_write_data   = out_if.io_write_data;
      r.clear_interrupt = out_if.clear_interrupt;
      r.halted          = out_if.halted;
      r.error           = out_if.error;
      sb.check_result(r);
      rx_count++;
    end
  end

  initial begin
    int waited;
    waited = 0;
    wait (stim_done);
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() == 0 && sb.mismatches == 0) begin
      $display("** risc_instruction_execute_top: PASSED **");
    end else begin
      $display("** risc_instruction_execute_top: FAILED **");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rie_pkg.sv
hw/rtl/rie_in_if.sv
hw/rtl/rie_out_if.sv
hw/rtl/rie_regfile.sv
hw/rtl/rie_dmem.sv
hw/rtl/risc_instruction_execute_top.sv
test/tb_scoreboard.sv
test/tb_top.sv
